[sv/amsd_pkg.sv]
`default_nettype none

package amsd_pkg;

    // One input transaction: a sample or a one millisecond tick.
    typedef logic signed [15:0] t_axis;

    typedef struct packed {
        logic  operation;
        t_axis accel_x;
        t_axis accel_y;
        t_axis accel_z;
    } t_in_item;

    // One result transaction.
    typedef struct packed {
        logic [31:0] step_total;
        logic        step_taken;
        logic [14:0] half_magnitude;
        logic        in_lockout;
    } t_out_item;

    typedef logic [31:0] t_sum;
    typedef logic [15:0] t_root;

    // Operation codes.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    // Configuration register indexes.
    localparam logic CFG_STEP_THRESHOLD = 1'b0;
    localparam logic CFG_LOCKOUT_MS     = 1'b1;

    localparam logic [15:0] RESET_THRESHOLD = 16'd10500;
    localparam logic [15:0] RESET_LOCKOUT   = 16'd500;
    localparam logic [31:0] STEP_MAX        = 32'hFFFF_FFFF;

endpackage

`default_nettype wire

[sv/amsd_sumsq.sv]
`default_nettype none

module amsd_sumsq (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire amsd_pkg::t_axis  i_x,
    input  wire amsd_pkg::t_axis  i_y,
    input  wire amsd_pkg::t_axis  i_z,
    output logic                  o_done,
    output amsd_pkg::t_sum        o_sum
);
    import amsd_pkg::*;

    // Magnitudes go through a three-entry shift line, one square per cycle.
    logic [16:0] r_abs [3];
    logic [30:0] r_prod;
    t_sum        r_acc;
    logic [1:0]  r_cnt;
    logic        r_busy;
    logic        r_done;
    logic [33:0] w_sq;

    function automatic logic [16:0] axis_abs(input t_axis a);
        logic [16:0] v;
        v = {a[15], a};
        return v[16] ? (17'd0 - v) : v;
    endfunction

    assign w_sq = r_abs[0] * r_abs[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_abs[0] <= axis_abs(i_x);
                r_abs[1] <= axis_abs(i_y);
                r_abs[2] <= axis_abs(i_z);
                r_prod   <= '0;
                r_acc    <= '0;
                r_cnt    <= '0;
                r_busy   <= 1'b1;
            end else if (r_busy) begin
                r_prod   <= w_sq[30:0];
                r_acc    <= r_acc + {1'b0, r_prod};
                r_abs[0] <= r_abs[1];
                r_abs[1] <= r_abs[2];
                r_abs[2] <= '0;
                r_cnt    <= r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_sum  = r_acc;

endmodule

`default_nettype wire

[sv/amsd_sqrt.sv]
`default_nettype none

module amsd_sqrt (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_start,
    input  wire amsd_pkg::t_sum  i_radicand,
    output logic                 o_done,
    output amsd_pkg::t_root      o_root
);
    import amsd_pkg::*;

    // Restoring square root, one root bit (two radicand bits) per cycle.
    t_sum        r_rad;
    logic [16:0] r_rem;
    t_root       r_root;
    logic [3:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [18:0] w_shift;
    logic [18:0] w_trial;
    logic [18:0] w_diff;
    logic        w_ge;

    assign w_shift = {r_rem, r_rad[31:30]};
    assign w_trial = {1'b0, r_root, 2'b01};
    assign w_ge    = (w_shift >= w_trial);
    assign w_diff  = w_shift - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rad  <= i_radicand;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                // The remainder never exceeds twice the partial root.
                r_rem  <= w_ge ? w_diff[16:0] : w_shift[16:0];
                r_root <= {r_root[14:0], w_ge};
                r_rad  <= {r_rad[29:0], 2'b00};
                r_cnt  <= r_cnt + 4'd1;
                if (r_cnt == 4'd15) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

`default_nettype wire

[sv/accel_magnitude_step_detector.sv]
`default_nettype none
// Channel   Direction  Handshake                    Payload
// input     in         i_in_valid / o_in_ready      i_in_data  (amsd_pkg::t_in_item)
// result    out        o_out_valid / i_out_ready    o_out_data (amsd_pkg::t_out_item)
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// A tick, or a sample that arrives during lockout, goes from idle straight to the finish
// state once accepted. An evaluated sample first passes the shared 17 x 17 squaring
// multiplier and then the bit-serial square root before it reaches the finish state.
// One transaction is worked on at a time; the next is accepted once the result has
// moved into the output register, so a stalled result blocks only the next finish.
// Synchronous active-low reset clears the step counter and the lockout and loads the
// default threshold and lockout length. The configuration port is always ready.

module accel_magnitude_step_detector (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire amsd_pkg::t_in_item   i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output amsd_pkg::t_out_item       o_out_data,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic                 i_cfg_index,
    input  wire logic [15:0]          i_cfg_data
);
    import amsd_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT,
        S_FINISH
    } t_state;

    t_state      r_state, n_state;
    t_in_item    r_item, n_item;
    logic [14:0] r_half, n_half;
    logic        r_eval, n_eval;
    logic [31:0] r_count, n_count;
    logic [15:0] r_lockout, n_lockout;
    logic [15:0] r_threshold, n_threshold;
    logic [15:0] r_lockout_ms, n_lockout_ms;
    logic        r_out_valid, n_out_valid;
    t_out_item   r_out, n_out;

    logic        w_accept;
    logic        w_free;
    logic        w_sq_start;
    logic        w_sq_done;
    t_sum        w_sum;
    logic        w_rt_start;
    logic        w_rt_done;
    t_root       w_root;
    logic        w_taken;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && o_in_ready;
    // The output register can take a new result when empty or being drained.
    assign w_free      = !r_out_valid || i_out_ready;

    // A sample is only evaluated when no lockout is pending at acceptance.
    assign w_sq_start = w_accept && (i_in_data.operation == OP_SAMPLE)
                        && (r_lockout == 16'd0);
    assign w_rt_start = (r_state == S_SQUARE) && w_sq_done;

    amsd_sumsq u_sumsq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_sq_start),
        .i_x     (i_in_data.accel_x),
        .i_y     (i_in_data.accel_y),
        .i_z     (i_in_data.accel_z),
        .o_done  (w_sq_done),
        .o_sum   (w_sum)
    );

    amsd_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_rt_start),
        .i_radicand (w_sum),
        .o_done     (w_rt_done),
        .o_root     (w_root)
    );

    assign w_taken = r_eval && ({1'b0, r_half} > r_threshold);

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_half       = r_half;
        n_eval       = r_eval;
        n_count      = r_count;
        n_lockout    = r_lockout;
        n_threshold  = r_threshold;
        n_lockout_ms = r_lockout_ms;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out        = r_out;

        if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_STEP_THRESHOLD: n_threshold  = i_cfg_data;
                CFG_LOCKOUT_MS:     n_lockout_ms = i_cfg_data;
                default: ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_item = i_in_data;
                    n_half = '0;
                    n_eval = w_sq_start;
                    n_state = w_sq_start ? S_SQUARE : S_FINISH;
                end
            end
            S_SQUARE: begin
                if (w_sq_done) begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (w_rt_done) begin
                    n_half  = w_root[15:1];
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (w_free) begin
                    // Commit the state update together with the result.
                    if (r_item.operation == OP_TICK) begin
                        if (r_lockout != 16'd0) begin
                            n_lockout = r_lockout - 16'd1;
                        end
                    end else if (w_taken) begin
                        if (r_count != STEP_MAX) begin
                            n_count = r_count + 32'd1;
                        end
                        n_lockout = r_lockout_ms;
                    end
                    n_out.step_total     = n_count;
                    n_out.step_taken     = w_taken;
                    n_out.half_magnitude = r_half;
                    n_out.in_lockout     = (n_lockout != 16'd0);
                    n_out_valid          = 1'b1;
                    n_state              = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_eval       <= 1'b0;
            r_count      <= '0;
            r_lockout    <= '0;
            r_threshold  <= RESET_THRESHOLD;
            r_lockout_ms <= RESET_LOCKOUT;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_eval       <= n_eval;
            r_count      <= n_count;
            r_lockout    <= n_lockout;
            r_threshold  <= n_threshold;
            r_lockout_ms <= n_lockout_ms;
            r_out_valid  <= n_out_valid;
        end
        r_item <= n_item;
        r_half <= n_half;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A reported step must have cleared the threshold in force.
    a_step_over_threshold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.step_taken
            |-> ({1'b0, o_out_data.half_magnitude} > r_threshold))
        else $error("step reported at or below threshold");

    // A step starts a lockout exactly when the lockout length is nonzero.
    a_step_lockout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.step_taken
            |-> (o_out_data.in_lockout == (r_lockout_ms != 16'd0)))
        else $error("step did not start the configured lockout");

    // The halved root of three squared 16-bit axes cannot exceed 28377.
    a_half_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.half_magnitude <= 15'd28377))
        else $error("half magnitude out of range");

    // A tick never reports an evaluation.
    a_tick_no_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FINISH) && (r_item.operation == OP_TICK) |-> !r_eval && (r_half == 15'd0))
        else $error("tick carried an evaluation");

endmodule

`default_nettype wire
